/* sv/tsp_pkg.sv */
package tsp_pkg;

  localparam int unsigned KIND_BITS = 3;
  localparam logic [2:0] KIND_CIRCLE = 3'd2;
  localparam logic [2:0] KIND_LINE   = 3'd4;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [0:0] REG_SHAPE_COUNT = 1'b0;
  localparam logic [0:0] REG_PICK_MARGIN = 1'b1;

  localparam int unsigned COUNT_BITS  = 7;
  localparam int unsigned MARGIN_BITS = 4;
  localparam logic [3:0] MARGIN_RESET = 4'd3;
  localparam int unsigned HIT_IDX_BITS = 6;

  typedef struct packed {
    logic [HIT_IDX_BITS-1:0] index;
    logic                    hit;
  } result_t;

endpackage

/* sv/tsp_front.sv */
module tsp_front #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 10,
  parameter int unsigned IDX_BITS    = 6,
  parameter int unsigned ENTRY_BITS  = 43
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  logic                    action_i,
  input  logic [5:0]              entry_index_i,
  input  logic [ENTRY_BITS-1:0]   entry_i,
  input  logic [COORD_BITS:0]     qx_i,
  input  logic [COORD_BITS:0]     qy_i,
  input  logic                    bk_idle_i,
  output logic                    wr_en_o,
  output logic [IDX_BITS-1:0]     wr_addr_o,
  output logic [ENTRY_BITS-1:0]   wr_data_o,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output logic [2*COORD_BITS+1:0] q_point_o
);

  logic                    full_q;
  logic [2*COORD_BITS+1:0] point_q;
  logic                    acc;

  // The table must not change under a running search.
  assign s_ready_o = !full_q && bk_idle_i;
  assign acc       = s_valid_i && s_ready_o;
  assign wr_en_o   = acc && (action_i == tsp_pkg::ACT_WRITE)
                     && ({26'd0, entry_index_i} < 32'(TABLE_DEPTH));
  assign wr_addr_o = IDX_BITS'(entry_index_i);
  assign wr_data_o = entry_i;
  assign q_valid_o = full_q;
  assign q_point_o = point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (acc && action_i == tsp_pkg::ACT_QUERY) begin
      full_q <= 1'b1;
    end else if (q_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && action_i == tsp_pkg::ACT_QUERY) begin
      point_q <= {qy_i, qx_i};
    end
  end

endmodule

/* sv/tsp_sqrt.sv */
module tsp_sqrt #(
  parameter int unsigned W = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   n_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);

  localparam int unsigned STEPS = W / 2;

  logic [W-1:0]           rem_q;
  logic [W/2-1:0]         root_q;
  logic [W/2+1:0]         acc_q;
  logic [$clog2(STEPS+1)-1:0] cnt_q;
  logic                   busy_q;
  logic [W/2+1:0]         trial;
  logic [W/2+1:0]         acc_sh;

  assign acc_sh = {acc_q[W/2-1:0], rem_q[W-1:W-2]};
  assign trial  = {root_q, 2'b01};
  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ($clog2(STEPS+1))'(STEPS);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= n_i;
      root_q <= '0;
      acc_q  <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= {rem_q[W-3:0], 2'b00};
      if (acc_sh >= trial) begin
        acc_q  <= acc_sh - trial;
        root_q <= {root_q[W/2-2:0], 1'b1};
      end else begin
        acc_q  <= acc_sh;
        root_q <= {root_q[W/2-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/tsp_back.sv */
module tsp_back #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 10,
  parameter int unsigned IDX_BITS    = 6,
  parameter int unsigned ENTRY_BITS  = 43
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [IDX_BITS-1:0]      wr_addr_i,
  input  logic [ENTRY_BITS-1:0]    wr_data_i,
  input  logic                     q_valid_i,
  output logic                     q_ready_o,
  output logic                     idle_o,
  input  logic [2*COORD_BITS+1:0]  q_point_i,
  input  logic [6:0]               shape_count_i,
  input  logic [3:0]               pick_margin_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output tsp_pkg::result_t         result_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = 2*CB + 4;  // signed work width
  localparam int unsigned PW = 2*CB + 6;  // product width
  localparam int unsigned RW = 2*CB + 4;  // radicand width (even)
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NEXT, ST_READ, ST_DIFF, ST_MUL1, ST_MUL2, ST_SQRT,
    ST_WAITR, ST_CROSS, ST_TEST, ST_OUT
  } state_e;

  logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_BITS-1:0] rd_q;

  state_e                state_q;
  logic [CW-1:0]         idx_q;
  logic signed [SW-1:0]  px_q, py_q, dx_q, dy_q, rx_q, ry_q;
  logic signed [PW-1:0]  p1_q, p2_q, p3_q, p4_q;
  logic signed [PW-1:0]  len2_q, along_q, cross_q;
  logic [RW/2-1:0]       root_q;
  logic signed [PW-1:0]  tolr_q;
  logic                  m_valid_q;
  tsp_pkg::result_t      res_q;

  logic [2:0]            kind;
  logic signed [SW-1:0]  ax, ay, bx, by, tol;
  logic                  sq_start, sq_done;
  logic [RW/2-1:0]       sq_root;
  logic                  hit;
  logic [CW-1:0]         lim;

  assign kind = rd_q[ENTRY_BITS-1 -: 3];
  assign ax = SW'({1'b0, rd_q[4*CB-1 -: CB]});
  assign ay = SW'({1'b0, rd_q[3*CB-1 -: CB]});
  assign bx = SW'({1'b0, rd_q[2*CB-1 -: CB]});
  assign by = SW'({1'b0, rd_q[CB-1:0]});
  assign tol = SW'({1'b0, pick_margin_i});

  assign lim = ({25'd0, shape_count_i} > 32'(TABLE_DEPTH)) ?
               CW'(TABLE_DEPTH) : CW'(shape_count_i);

  assign sq_start = (state_q == ST_SQRT);

  tsp_sqrt #(.W(RW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start),
    .n_i(RW'(len2_q)), .done_o(sq_done), .root_o(sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[IDX_BITS'(idx_q - 1'b1)];
  end

  logic signed [SW-1:0] r_s, h_s, lx, hx, ly, hy;
  always_comb begin
    r_s = SW'({1'b0, root_q});
    h_s = r_s >>> 1;
    lx = (ax < bx ? ax : bx) - tol;
    hx = (ax > bx ? ax : bx) + tol;
    ly = (ay < by ? ay : by) - tol;
    hy = (ay > by ? ay : by) + tol;
    if (kind == tsp_pkg::KIND_CIRCLE) begin
      lx = ax - r_s - tol;
      hx = ax + r_s + tol;
      ly = ay - h_s - tol;
      hy = ay + h_s + tol;
    end
    if (kind == tsp_pkg::KIND_LINE) begin
      if (len2_q == '0) begin
        hit = (rx_q <= tol) && (-rx_q <= tol) && (ry_q <= tol) && (-ry_q <= tol);
      end else begin
        hit = (along_q >= 0) && (along_q <= len2_q) && (cross_q <= tolr_q);
      end
    end else begin
      hit = px_q >= lx && px_q <= hx && py_q >= ly && py_q <= hy;
    end
  end

  assign q_ready_o = (state_q == ST_IDLE) && !m_valid_q;
  assign idle_o    = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign result_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
      res_q     <= '0;
    end else begin
      if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && !m_valid_q) begin
            idx_q   <= lim;
            res_q   <= '0;
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: state_q <= (idx_q == '0) ? ST_OUT : ST_READ;
        ST_READ: state_q <= ST_DIFF;
        ST_DIFF: state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_SQRT;
        ST_SQRT: state_q <= ST_WAITR;
        ST_WAITR: begin
          if (sq_done) begin
            state_q <= ST_CROSS;
          end
        end
        ST_CROSS: state_q <= ST_TEST;
        ST_TEST: begin
          if (hit) begin
            res_q.hit   <= 1'b1;
            res_q.index <= tsp_pkg::HIT_IDX_BITS'(idx_q - 1'b1);
            state_q     <= ST_OUT;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= ST_NEXT;
          end
        end
        ST_OUT: begin
          m_valid_q <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q <= SW'($signed(q_point_i[CB:0]));
        py_q <= SW'($signed(q_point_i[2*CB+1:CB+1]));
      end
      ST_DIFF: begin
        dx_q <= bx - ax;
        dy_q <= (kind == tsp_pkg::KIND_CIRCLE) ? (by - ay) <<< 1 : by - ay;
        rx_q <= px_q - ax;
        ry_q <= py_q - ay;
      end
      ST_MUL1: begin
        p1_q <= PW'(dx_q * dx_q);
        p2_q <= PW'(dy_q * dy_q);
        p3_q <= PW'(rx_q * dx_q);
        p4_q <= PW'(ry_q * dy_q);
      end
      ST_MUL2: begin
        len2_q  <= p1_q + p2_q;
        along_q <= p3_q + p4_q;
        p1_q    <= PW'(rx_q * dy_q);
        p2_q    <= PW'(ry_q * dx_q);
      end
      ST_WAITR: begin
        root_q  <= sq_root;
        cross_q <= (p1_q - p2_q) < 0 ? p2_q - p1_q : p1_q - p2_q;
      end
      ST_CROSS: begin
        tolr_q <= PW'($signed({1'b0, pick_margin_i}) * $signed({1'b0, root_q}));
      end
      default: ;
    endcase
  end

endmodule

/* sv/topmost_shape_pick_unit.sv */
// Channel   | Signals                               | Word
// s_axis    | s_axis_tvalid/tready/tdata/tuser      | write entry or pick query
// m_axis    | m_axis_tvalid/tready/tdata/tuser      | pick result
// cfg       | cfg_valid/ready/index/data            | register write
// A write is stored at the edge that accepts it. For each entry visited, a query reads
// the entry, forms the differences and the products, waits on the bit-serial square
// root, and tests for a hit. Reset sets the pick margin to 3 and clears all other
// control state; table entries hold no value until written.
// The input holds off while a search runs. Writes are taken again once it ends, even
// while its result stalls, and one query waits meanwhile in a single-entry queue.
module topmost_shape_pick_unit #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: entry_index, entry_kind, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // query_x, query_y, zero fill
  input  logic [((6+3+6*COORD_BITS+2)+7)/8*8-1:0] s_axis_tdata,
  // tuser: action
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: hit_index
  output logic [7:0]                m_axis_tdata,
  // tuser: hit
  output logic                      m_axis_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [7:0]                cfg_data
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ENTRY_BITS = 3 + 4*CB;

  logic [6:0]                 count_q;
  logic [3:0]                 margin_q;
  logic                       wr_en, q_valid, q_ready, m_valid, bk_idle;
  logic [IDX_BITS-1:0]        wr_addr;
  logic [ENTRY_BITS-1:0]      wr_data;
  logic [2*CB+1:0]            q_point;
  tsp_pkg::result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      margin_q <= tsp_pkg::MARGIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsp_pkg::REG_SHAPE_COUNT: count_q  <= cfg_data[6:0];
        tsp_pkg::REG_PICK_MARGIN: margin_q <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tsp_front #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(CB), .IDX_BITS(IDX_BITS),
              .ENTRY_BITS(ENTRY_BITS)) u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .action_i(s_axis_tuser),
    .entry_index_i(s_axis_tdata[5:0]),
    .entry_i({s_axis_tdata[8:6], s_axis_tdata[9 +: CB], s_axis_tdata[9+CB +: CB],
              s_axis_tdata[9+2*CB +: CB], s_axis_tdata[9+3*CB +: CB]}),
    .qx_i(s_axis_tdata[9+4*CB +: CB+1]),
    .qy_i(s_axis_tdata[10+5*CB +: CB+1]),
    .bk_idle_i(bk_idle),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_point_o(q_point)
  );

  tsp_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(CB), .IDX_BITS(IDX_BITS),
             .ENTRY_BITS(ENTRY_BITS)) u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .idle_o(bk_idle), .q_point_i(q_point),
    .shape_count_i(count_q), .pick_margin_i(margin_q),
    .m_valid_o(m_valid), .m_ready_i(m_axis_tready), .result_o(res)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {2'b00, res.index};
  assign m_axis_tuser  = res.hit;

  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("miss with nonzero index");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_qhold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_ready |=> q_valid)
    else $error("queued query lost");

endmodule
